FILE: src/compass_heading_validator_unit_assert.svh
// ----------------------------------------------------------------------------
// Compass heading validator assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_VALIDATOR_UNIT_ASSERT_SVH
`define COMPASS_HEADING_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CHV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CHV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/chv_pkg.sv
// ----------------------------------------------------------------------------
// chv_pkg
// Shared types, reason codes and arctangent step constants for the
// compass heading validator.
// ----------------------------------------------------------------------------
package chv_pkg;

    // Reject reason codes
    localparam logic [2:0] RSN_OK   = 3'd0;
    localparam logic [2:0] RSN_LINK = 3'd1;
    localparam logic [2:0] RSN_READ = 3'd2;
    localparam logic [2:0] RSN_ZERO = 3'd3;
    localparam logic [2:0] RSN_ONES = 3'd4;
    localparam logic [2:0] RSN_OVF  = 3'd5;

    // Status byte overflow flag position
    localparam int STATUS_OVF_BIT = 2;

    // Field widths
    localparam int AXIS_W    = 16;
    localparam int MAG_W     = AXIS_W + 1;
    localparam int HEADING_W = 15;

    // Defaults for top-level parameters
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // CORDIC sizing: Q30 inputs and Q30 degree angles
    localparam int DEG_Q   = 30;
    localparam int STEPS   = 32;
    localparam int XY_W    = MAG_W + DEG_Q + 2;
    localparam int Z_W     = 40;

    // 180/pi in Q24
    localparam logic [63:0] RAD_TO_DEG_Q24 = 64'd961263669;

    // Classified item handed from the front part to the back part
    typedef struct packed {
        logic [2:0]               reason;
        logic signed [AXIS_W-1:0] x_val;
        logic signed [AXIS_W-1:0] y_val;
        logic signed [AXIS_W-1:0] z_val;
        logic [MAG_W-1:0]         mag_a;
        logic [MAG_W-1:0]         mag_b;
        logic                     swap;
        logic                     xneg;
        logic                     yneg;
        logic                     bzero;
    } chv_item_t;

    // Side information carried alongside the rotation stages
    typedef struct packed {
        logic [2:0]               reason;
        logic signed [AXIS_W-1:0] x_val;
        logic signed [AXIS_W-1:0] y_val;
        logic signed [AXIS_W-1:0] z_val;
        logic                     swap;
        logic                     xneg;
        logic                     yneg;
        logic                     bzero;
    } chv_meta_t;

    // atan(2^-i) in Q30 degrees, by power series in Q60 radians
    function automatic logic [63:0] atan_step_deg(input int i);
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] hi;
        logic [63:0] lo;
        int          e;
        logic        done;
        r    = 64'd0;
        done = 1'b0;
        for (int k = 0; k < 64; k++) begin
            e = (2 * k + 1) * i;
            if (e > 60)
                done = 1'b1;
            if (!done) begin
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                if ((k % 2) == 1)
                    r = r - term;
                else
                    r = r + term;
            end
        end
        hi = (r >> 30) * RAD_TO_DEG_Q24;
        lo = ((r & ((64'd1 << 30) - 64'd1)) * RAD_TO_DEG_Q24) >> 30;
        return (hi + lo) >> 24;
    endfunction

endpackage

FILE: src/compass_heading_validator_unit.sv
// ----------------------------------------------------------------------------
// compass_heading_validator_unit
// Validates magnetometer samples and gives the compass heading of good ones.
// ----------------------------------------------------------------------------
// Input stream: one sample per request; tuser carries link_up, read_ok and
// ready_seen, tdata carries the status byte and the x, y, z readings.
// Output stream: one result per sample, in order; tuser carries sample_good
// and reject_reason, tdata the readings passed through and the heading in
// units of 2^-ANGLE_FRAC_BITS degree.
// Path: from the accepting edge, a sample passes the front register, the queue,
// a 33-register CORDIC chain of 32 rotations, two unfold stages and the
// output register before its result is shown.
// Throughput: one sample per cycle; the 32-stage rotation pipeline sets it.
// When the receiver stalls the whole back pipeline holds; the queue and the
// front register keep taking samples until the queue fills.
// Reset clears all valid flags and queue pointers; no samples are in flight
// afterwards and the block is ready at once.
// ----------------------------------------------------------------------------
`include "compass_heading_validator_unit_assert.svh"

module compass_heading_validator_unit
    import chv_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_byte, [23:8] x_value, [39:24] y_value, [55:40] z_value
    input  logic [55:0] s_axis_tdata,
    // [0] link_up, [1] read_ok, [2] ready_seen
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] x_out, [31:16] y_out, [47:32] z_out, [62:48] heading, [63] zero
    output logic [63:0] m_axis_tdata,
    // [0] sample_good, [3:1] reject_reason
    output logic [3:0]  m_axis_tuser
);

    logic      fq_valid;
    logic      fq_ready;
    chv_item_t fq_item;
    logic      qb_valid;
    logic      qb_ready;
    chv_item_t qb_item;

    // Classify incoming samples
    chv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    // Decouple front and back
    chv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Compute heading and drive the result stream
    chv_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_item       (qb_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Good flag and reason agree
    `CHV_ASSERT_SAME(a_good_means_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:1] == RSN_OK, "good sample carries a reject reason")

    // Rejected samples carry no heading
    `CHV_ASSERT_SAME(a_reject_no_heading, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[62:48] == '0, "rejected sample carries a heading")

    // Readings not received are zeroed
    `CHV_ASSERT_SAME(a_missing_zeroed, m_axis_tvalid && (m_axis_tuser[3:1] == RSN_LINK || m_axis_tuser[3:1] == RSN_READ), m_axis_tdata[47:0] == '0, "missing readings not zeroed")

    // A stalled result stays put until taken
    `CHV_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

FILE: src/chv_front.sv
// ----------------------------------------------------------------------------
// chv_front
// Accepts samples, runs the ordered validity checks and prepares the
// octant reduction for the heading pipeline.
// ----------------------------------------------------------------------------
module chv_front
    import chv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] status_byte, [23:8] x_value, [39:24] y_value, [55:40] z_value
    input  logic [55:0]       s_axis_tdata,
    // [0] link_up, [1] read_ok, [2] ready_seen
    input  logic [2:0]        s_axis_tuser,
    output logic              q_valid,
    input  logic              q_ready,
    output chv_item_t         q_item
);

    logic                     link_up;
    logic                     read_ok;
    logic                     ready_seen;
    logic [7:0]               status_byte;
    logic signed [AXIS_W-1:0] x_value;
    logic signed [AXIS_W-1:0] y_value;
    logic signed [AXIS_W-1:0] z_value;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic                     received;
    chv_item_t                item_next;
    chv_item_t                item_reg;
    logic                     valid_reg;
    logic                     accept;

    assign link_up     = s_axis_tuser[0];
    assign read_ok     = s_axis_tuser[1];
    assign ready_seen  = s_axis_tuser[2];
    assign status_byte = s_axis_tdata[7:0];
    assign x_value     = s_axis_tdata[23:8];
    assign y_value     = s_axis_tdata[39:24];
    assign z_value     = s_axis_tdata[55:40];

    assign received = link_up && read_ok;

    // Take absolute values at one extra bit so the most negative reading fits
    assign ax = x_value[AXIS_W-1] ? (MAG_W'(0) - {x_value[AXIS_W-1], x_value})
                                  : {1'b0, x_value};
    assign ay = y_value[AXIS_W-1] ? (MAG_W'(0) - {y_value[AXIS_W-1], y_value})
                                  : {1'b0, y_value};

    // Classify in priority order and fold into the first octant
    always_comb
    begin
        item_next.swap  = (ay > ax);
        item_next.mag_a = item_next.swap ? ay : ax;
        item_next.mag_b = item_next.swap ? ax : ay;
        item_next.bzero = (item_next.mag_b == MAG_W'(0));
        item_next.xneg  = x_value[AXIS_W-1];
        item_next.yneg  = y_value[AXIS_W-1];
        item_next.x_val = received ? x_value : '0;
        item_next.y_val = received ? y_value : '0;
        item_next.z_val = received ? z_value : '0;
        priority if (!link_up)
            item_next.reason = RSN_LINK;
        else if (!read_ok)
            item_next.reason = RSN_READ;
        else if (x_value == '0 && y_value == '0 && z_value == '0)
            item_next.reason = RSN_ZERO;
        else if (x_value == '1 && y_value == '1 && z_value == '1)
            item_next.reason = RSN_ONES;
        else if (ready_seen && status_byte[STATUS_OVF_BIT])
            item_next.reason = RSN_OVF;
        else
            item_next.reason = RSN_OK;
    end

    // Hold the classified request until the queue takes it
    assign s_axis_tready = !valid_reg || q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_axis_tready)
            valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

FILE: src/chv_queue.sv
// ----------------------------------------------------------------------------
// chv_queue
// Short first-in first-out queue of classified requests between the
// front and back parts. The oldest request sits in an output register.
// ----------------------------------------------------------------------------
module chv_queue
    import chv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  chv_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output chv_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    chv_item_t        mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    chv_item_t        out_item_reg;
    logic             out_valid_reg;
    logic             push;
    logic             load;
    logic             from_mem;
    logic             bypass;
    logic             to_mem;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign push      = in_valid && in_ready;

    // Refill the output register from storage, or straight from the input
    // when storage is empty
    assign load     = !out_valid_reg || out_ready;
    assign from_mem = load && (count_reg != CNT_W'(0));
    assign bypass   = load && (count_reg == CNT_W'(0)) && push;
    assign to_mem   = push && !bypass;

    // Track occupancy of the storage behind the output register
    always_comb
    begin
        count_next = count_reg;
        if (to_mem && !from_mem)
            count_next = count_reg + CNT_W'(1);
        else if (from_mem && !to_mem)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers, wrapping at the depth, and update occupancy and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (load)
                out_valid_reg <= from_mem || bypass;
            if (to_mem)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (from_mem)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        end
    end

    // Store the incoming request and read the oldest one out
    always_ff @(posedge clk)
    begin
        if (to_mem)
            mem[wr_ptr_reg] <= in_item;
        if (from_mem)
            out_item_reg <= mem[rd_ptr_reg];
        else if (bypass)
            out_item_reg <= in_item;
    end

endmodule

FILE: src/chv_back.sv
// ----------------------------------------------------------------------------
// chv_back
// Pipelined CORDIC vectoring on the first octant, octant unfolding,
// rounding and the output register.
// ----------------------------------------------------------------------------
module chv_back
    import chv_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  chv_item_t   in_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] x_out, [31:16] y_out, [47:32] z_out, [62:48] heading, [63] zero
    output logic [63:0] m_axis_tdata,
    // [0] sample_good, [3:1] reject_reason
    output logic [3:0]  m_axis_tuser
);

    localparam logic [Z_W-1:0] DEG45      = Z_W'(64'd45 << DEG_Q);
    localparam logic [Z_W-1:0] DEG90      = Z_W'(64'd90 << DEG_Q);
    localparam logic [Z_W-1:0] DEG180     = Z_W'(64'd180 << DEG_Q);
    localparam logic [Z_W-1:0] DEG360     = Z_W'(64'd360 << DEG_Q);
    localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(64'd1 << (DEG_Q - 1 - ANGLE_FRAC_BITS));
    localparam int             RSH        = DEG_Q - ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0] FULL_TURN  = Z_W'(64'd360 << ANGLE_FRAC_BITS);

    logic                   pipe_en;
    logic signed [XY_W-1:0] cx_reg [0:STEPS];
    logic signed [XY_W-1:0] cy_reg [0:STEPS];
    logic signed [Z_W-1:0]  cz_reg [0:STEPS];
    chv_meta_t              cm_reg [0:STEPS];
    logic [STEPS:0]         cv_reg;

    logic [Z_W-1:0]         clamp_ang;
    logic [Z_W-1:0]         p1_ang_reg;
    chv_meta_t              p1_meta_reg;
    logic                   p1_valid_reg;
    logic [Z_W-1:0]         p2_full_reg;
    chv_meta_t              p2_meta_reg;
    logic                   p2_valid_reg;
    logic [Z_W-1:0]         units;
    logic [HEADING_W-1:0]   heading_next;
    logic                   out_valid_reg;
    logic [63:0]            out_data_reg;
    logic [3:0]             out_user_reg;
    chv_meta_t              in_meta;

    // Whole pipeline moves whenever the output register can take a request
    assign pipe_en  = !out_valid_reg || m_axis_tready;
    assign in_ready = pipe_en;

    assign in_meta.reason = in_item.reason;
    assign in_meta.x_val  = in_item.x_val;
    assign in_meta.y_val  = in_item.y_val;
    assign in_meta.z_val  = in_item.z_val;
    assign in_meta.swap   = in_item.swap;
    assign in_meta.xneg   = in_item.xneg;
    assign in_meta.yneg   = in_item.yneg;
    assign in_meta.bzero  = in_item.bzero;

    // Valid chain through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg        <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            cv_reg        <= {cv_reg[STEPS-1:0], in_valid};
            p1_valid_reg  <= cv_reg[STEPS];
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    // Load the scaled octant vector
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cx_reg[0] <= {{(XY_W - MAG_W - DEG_Q){1'b0}}, in_item.mag_a, {DEG_Q{1'b0}}};
            cy_reg[0] <= {{(XY_W - MAG_W - DEG_Q){1'b0}}, in_item.mag_b, {DEG_Q{1'b0}}};
            cz_reg[0] <= '0;
            cm_reg[0] <= in_meta;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 1; i <= STEPS; i++)
    begin : g_rot
        localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_step_deg(i));
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;

        // Shift towards zero, as a magnitude shift
        assign dx = cy_reg[i-1][XY_W-1] ? -((-cy_reg[i-1]) >>> i) : (cy_reg[i-1] >>> i);
        assign dy = cx_reg[i-1] >>> i;

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                if (!cy_reg[i-1][XY_W-1])
                begin
                    cx_reg[i] <= cx_reg[i-1] + dx;
                    cy_reg[i] <= cy_reg[i-1] - dy;
                    cz_reg[i] <= cz_reg[i-1] + ANG;
                end
                else
                begin
                    cx_reg[i] <= cx_reg[i-1] - dx;
                    cy_reg[i] <= cy_reg[i-1] + dy;
                    cz_reg[i] <= cz_reg[i-1] - ANG;
                end
                cm_reg[i] <= cm_reg[i-1];
            end
        end
    end

    // Clamp to the octant; a zero minor axis gives angle zero
    always_comb
    begin
        priority if (cm_reg[STEPS].bzero || cz_reg[STEPS][Z_W-1])
            clamp_ang = '0;
        else if ($unsigned(cz_reg[STEPS]) > DEG45)
            clamp_ang = DEG45;
        else
            clamp_ang = $unsigned(cz_reg[STEPS]);
    end

    // Undo the axis swap, then the quadrant fold
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            p1_ang_reg  <= cm_reg[STEPS].swap ? (DEG90 - clamp_ang) : clamp_ang;
            p1_meta_reg <= cm_reg[STEPS];
            p2_meta_reg <= p1_meta_reg;
            priority if (!p1_meta_reg.xneg && !p1_meta_reg.yneg)
                p2_full_reg <= p1_ang_reg;
            else if (p1_meta_reg.xneg && !p1_meta_reg.yneg)
                p2_full_reg <= DEG180 - p1_ang_reg;
            else if (p1_meta_reg.xneg)
                p2_full_reg <= DEG180 + p1_ang_reg;
            else
                p2_full_reg <= DEG360 - p1_ang_reg;
        end
    end

    // Round half up, wrap a full turn to zero, zero the heading on reject
    assign units = (p2_full_reg + ROUND_HALF) >> RSH;

    always_comb
    begin
        if (p2_meta_reg.reason != RSN_OK || units >= FULL_TURN)
            heading_next = '0;
        else
            heading_next = units[HEADING_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_data_reg <= {1'b0, heading_next, p2_meta_reg.z_val,
                             p2_meta_reg.y_val, p2_meta_reg.x_val};
            out_user_reg <= {p2_meta_reg.reason, (p2_meta_reg.reason == RSN_OK)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: tb/sv/compass_heading_validator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compass_heading_validator_unit_tb
// Self-checking bench for the compass heading validator. A directed table
// covers the reject reasons, their priority and the heading extremes. A long
// random run follows, with gaps on both streams. Every result is checked
// against a typed table answer or the in-bench CORDIC predictor, in order.
// ----------------------------------------------------------------------------
module compass_heading_validator_unit_tb;
    import chv_pkg::*;

    localparam int  FRAC        = ANGLE_FRAC_BITS_DEF;
    localparam int  FULL_TURN   = 360 << FRAC;
    localparam int  RANDOM_REQS = 1800;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  CYCLE_LIMIT = 900000;

    // One sensor sample as it enters the block
    typedef struct {
        logic                     link_up;
        logic                     read_ok;
        logic                     ready_seen;
        logic [7:0]               status_byte;
        logic signed [AXIS_W-1:0] x_value;
        logic signed [AXIS_W-1:0] y_value;
        logic signed [AXIS_W-1:0] z_value;
    } sample_t;

    // One validated reading as it leaves the block
    typedef struct {
        logic                        good;
        logic [2:0]                  reason;
        logic signed [AXIS_W-1:0]    x_out;
        logic signed [AXIS_W-1:0]    y_out;
        logic signed [AXIS_W-1:0]    z_out;
        logic [HEADING_W-1:0]        heading;
    } reading_t;

    // Directed row: sample plus, where obvious, the typed answer
    typedef struct {
        sample_t              smp;
        logic                 typed;
        logic                 good;
        logic [2:0]           reason;
        logic [HEADING_W-1:0] heading;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    reading_t       awaited_readings[$];
    directed_row_t  directed_rows[$];
    longint         atan_q30[1:STEPS];
    int             error_count = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    logic           quiet = 1'b0;

    compass_heading_validator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Heading predictor
    // ------------------------------------------------------------------------

    // atan(2^-i) by power series in Q60 radians, then to Q30 degrees
    function automatic longint series_atan_q30(int i);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] hi;
        logic [63:0] lo;
        int          k;
        acc = 64'd0;
        k   = 0;
        while ((2 * k + 1) * i <= 60)
        begin
            term = (64'd1 << (60 - (2 * k + 1) * i)) / 64'(2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
            k++;
        end
        hi = (acc >> 30) * RAD_TO_DEG_Q24;
        lo = ((acc & ((64'd1 << 30) - 64'd1)) * RAD_TO_DEG_Q24) >> 30;
        return longint'((hi + lo) >> 24);
    endfunction

    // Arithmetic shift that rounds toward zero
    function automatic longint shift_toward_zero(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    // Angle of (a, b) with 0 <= b <= a, Q30 degrees, clamped to [0, 45]
    function automatic longint octant_angle(longint a, longint b);
        longint cx;
        longint cy;
        longint cz;
        longint dx;
        longint dy;
        if (b == 0)
            return 0;
        cx = a <<< DEG_Q;
        cy = b <<< DEG_Q;
        cz = 0;
        for (int i = 1; i <= STEPS; i++)
        begin
            dx = shift_toward_zero(cy, i);
            dy = shift_toward_zero(cx, i);
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + atan_q30[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - atan_q30[i];
            end
        end
        if (cz < 0)
            cz = 0;
        if (cz > (longint'(45) <<< DEG_Q))
            cz = longint'(45) <<< DEG_Q;
        return cz;
    endfunction

    // Compass heading of (x, y) in units of 2^-FRAC degree
    function automatic logic [HEADING_W-1:0] heading_units(longint xv, longint yv);
        longint ax;
        longint ay;
        longint one;
        longint a;
        longint full;
        longint units;
        ax  = (xv < 0) ? -xv : xv;
        ay  = (yv < 0) ? -yv : yv;
        one = longint'(1) <<< DEG_Q;
        if (ax == 0 && ay == 0)
            return '0;
        if (ay <= ax)
            a = octant_angle(ax, ay);
        else
            a = 90 * one - octant_angle(ay, ax);
        if (xv >= 0 && yv >= 0)
            full = a;
        else if (xv < 0 && yv >= 0)
            full = 180 * one - a;
        else if (xv < 0)
            full = 180 * one + a;
        else
            full = 360 * one - a;
        units = (full + (longint'(1) <<< (DEG_Q - 1 - FRAC))) >>> (DEG_Q - FRAC);
        // A value that rounds up to a full turn wraps to north
        if (units >= FULL_TURN)
            units = 0;
        return units[HEADING_W-1:0];
    endfunction

    // Validate one sample and give the reading the block must return
    function automatic reading_t predict_reading(sample_t s);
        reading_t r;
        r.good    = 1'b0;
        r.x_out   = s.x_value;
        r.y_out   = s.y_value;
        r.z_out   = s.z_value;
        r.heading = '0;
        if (!s.link_up || !s.read_ok)
        begin
            r.reason = s.link_up ? RSN_READ : RSN_LINK;
            r.x_out  = '0;
            r.y_out  = '0;
            r.z_out  = '0;
        end
        else if (s.x_value == 0 && s.y_value == 0 && s.z_value == 0)
            r.reason = RSN_ZERO;
        else if (s.x_value == -1 && s.y_value == -1 && s.z_value == -1)
            r.reason = RSN_ONES;
        else if (s.ready_seen && s.status_byte[STATUS_OVF_BIT])
            r.reason = RSN_OVF;
        else
        begin
            r.reason  = RSN_OK;
            r.good    = 1'b1;
            r.heading = heading_units(longint'(s.x_value), longint'(s.y_value));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_row(int lk, int rd, int rdy, logic [7:0] st,
                                    int xv, int yv, int zv, int typed,
                                    int good, logic [2:0] reason, int hd);
        directed_row_t row;
        row.smp.link_up     = lk[0];
        row.smp.read_ok     = rd[0];
        row.smp.ready_seen  = rdy[0];
        row.smp.status_byte = st;
        row.smp.x_value     = xv[AXIS_W-1:0];
        row.smp.y_value     = yv[AXIS_W-1:0];
        row.smp.z_value     = zv[AXIS_W-1:0];
        row.typed           = typed[0];
        row.good            = good[0];
        row.reason          = reason;
        row.heading         = hd[HEADING_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return 16'($urandom_range(0, 65535));
        if (mode < 7)
            return 16'($signed($urandom_range(0, 8)) - 4);
        if (mode == 7)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($signed($urandom_range(0, 600)) - 300);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      kind;
        kind          = $urandom_range(0, 99);
        s.link_up     = 1'b1;
        s.read_ok     = 1'b1;
        s.ready_seen  = 1'($urandom_range(0, 1));
        s.status_byte = 8'($urandom_range(0, 255));
        s.x_value     = pick_axis();
        s.y_value     = pick_axis();
        s.z_value     = pick_axis();
        if (kind < 4)
        begin
            s.link_up = 1'b0;
            s.read_ok = 1'($urandom_range(0, 1));
        end
        else if (kind < 8)
            s.read_ok = 1'b0;
        else if (kind < 11)
        begin
            s.x_value = '0;
            s.y_value = '0;
            s.z_value = '0;
        end
        else if (kind < 14)
        begin
            s.x_value = '1;
            s.y_value = '1;
            s.z_value = '1;
        end
        return s;
    endfunction

    // Offer one sample after an idle gap and log its expected reading on
    // acceptance; entered and left just after a falling edge
    task automatic send_sample(sample_t s, reading_t want, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.z_value, s.y_value, s.x_value, s.status_byte};
        s_axis_tuser  <= {s.ready_seen, s.read_ok, s.link_up};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        awaited_readings.push_back(want);
        @(negedge clk);
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got,
                 want);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure with quiet stretches
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        reading_t want;
        int       diff;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_readings.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = awaited_readings.pop_front();
                if (m_axis_tuser[0] !== want.good)
                    report_mismatch("sample_good", longint'(m_axis_tuser[0]),
                                    longint'(want.good));
                if (m_axis_tuser[3:1] !== want.reason)
                    report_mismatch("reject_reason", longint'(m_axis_tuser[3:1]),
                                    longint'(want.reason));
                if (m_axis_tdata[15:0] !== want.x_out)
                    report_mismatch("x_out", longint'($signed(m_axis_tdata[15:0])),
                                    longint'(want.x_out));
                if (m_axis_tdata[31:16] !== want.y_out)
                    report_mismatch("y_out", longint'($signed(m_axis_tdata[31:16])),
                                    longint'(want.y_out));
                if (m_axis_tdata[47:32] !== want.z_out)
                    report_mismatch("z_out", longint'($signed(m_axis_tdata[47:32])),
                                    longint'(want.z_out));
                if (m_axis_tdata[63] !== 1'b0)
                    report_mismatch("tdata pad bit", longint'(m_axis_tdata[63]), 0);
                // Allow one unit either way, counting across north
                diff = int'(m_axis_tdata[62:48]) - int'(want.heading);
                if (diff < 0)
                    diff = -diff;
                if (diff == FULL_TURN - 1)
                    diff = 1;
                if ($isunknown(m_axis_tdata[62:48]) || diff > 1)
                    report_mismatch("heading", longint'(m_axis_tdata[62:48]),
                                    longint'(want.heading));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        sample_t  smp;
        reading_t want;
        for (int i = 1; i <= STEPS; i++)
            atan_q30[i] = series_atan_q30(i);

        // Reject reasons and their priority
        add_row(0, 1, 1, 8'h04, 123, -456, 789, 1, 0, RSN_LINK, 0);
        add_row(0, 0, 0, 8'h00, -1, -1, -1, 1, 0, RSN_LINK, 0);
        add_row(1, 0, 1, 8'hFF, 32767, -32768, 5, 1, 0, RSN_READ, 0);
        add_row(1, 1, 1, 8'h04, 0, 0, 0, 1, 0, RSN_ZERO, 0);
        add_row(1, 1, 1, 8'hFF, -1, -1, -1, 1, 0, RSN_ONES, 0);
        add_row(1, 1, 1, 8'h04, 100, 50, 7, 1, 0, RSN_OVF, 0);
        add_row(1, 1, 1, 8'hFF, -32768, 32767, -32768, 1, 0, RSN_OVF, 0);
        // Overflow bit ignored without ready, other status bits ignored
        add_row(1, 1, 0, 8'h04, 100, 50, 7, 0, 0, RSN_OK, 0);
        add_row(1, 1, 1, 8'hFB, 100, 50, 7, 0, 0, RSN_OK, 0);
        // Cardinal points and the origin
        add_row(1, 1, 0, 8'h00, 0, 0, 5, 1, 1, RSN_OK, 0);
        add_row(1, 1, 1, 8'h00, 0, 0, -1, 1, 1, RSN_OK, 0);
        add_row(1, 1, 1, 8'h00, 1, 0, 0, 1, 1, RSN_OK, 0);
        add_row(1, 1, 1, 8'h00, 0, 1, 0, 1, 1, RSN_OK, 90 << FRAC);
        add_row(1, 1, 1, 8'h00, -1, 0, 0, 1, 1, RSN_OK, 180 << FRAC);
        add_row(1, 1, 1, 8'h00, 0, -1, 0, 1, 1, RSN_OK, 270 << FRAC);
        add_row(1, 1, 0, 8'h00, 0, 32767, 32767, 1, 1, RSN_OK, 90 << FRAC);
        add_row(1, 1, 0, 8'h00, -32768, 0, -32768, 1, 1, RSN_OK, 180 << FRAC);
        // Diagonals, extremes and the wrap at a full turn
        add_row(1, 1, 0, 8'h00, 1, 1, 0, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, -1, -1, 0, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, 32767, 32767, 1, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, -32768, -32768, 0, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, -32768, 32767, -2, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, 32767, -1, 0, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'h00, 32767, -32768, 32767, 0, 0, RSN_OK, 0);
        add_row(1, 1, 0, 8'hFB, 3, -7, 0, 0, 0, RSN_OK, 0);

        // Hold reset, then release it on a falling edge
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            smp = directed_rows[i].smp;
            if (directed_rows[i].typed)
            begin
                want.good    = directed_rows[i].good;
                want.reason  = directed_rows[i].reason;
                want.heading = directed_rows[i].heading;
                if (want.reason == RSN_LINK || want.reason == RSN_READ)
                begin
                    want.x_out = '0;
                    want.y_out = '0;
                    want.z_out = '0;
                end
                else
                begin
                    want.x_out = smp.x_value;
                    want.y_out = smp.y_value;
                    want.z_out = smp.z_value;
                end
            end
            else
                want = predict_reading(smp);
            send_sample(smp, want, pick_gap());
        end

        // Random run, with stretches of full-rate traffic
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            smp = random_sample();
            send_sample(smp, predict_reading(smp), pick_gap());
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        // Drain, then allow for anything stray past the pipeline depth
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/chv_pkg.sv
src/chv_front.sv
src/chv_queue.sv
src/chv_back.sv
src/compass_heading_validator_unit.sv
tb/sv/compass_heading_validator_unit_tb.sv
